@@ hdl/assert_macros.svh @@
// Assertion macros shared by the easing block modules.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BEI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BEI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BEI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BEI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bei_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types of the Bezier easing block.
// No dependencies.
package bei_pkg;
	localparam int NUM_CURVES_DEF = 16;
	localparam int PTS_PER_CURVE = 4;
	localparam int CURVE_W = 4;
	localparam int POINT_W = 2;
	localparam int PT_W = 16;
	localparam int TIME_W = 13;
	localparam int POS_W = 32;
	localparam int LANES = 3;
	localparam int FRAC_W = 12;
	localparam int HALF_Q12 = 2048;
	localparam logic [TIME_W-1:0] ONE_Q12 = 13'd4096;
	localparam logic FUNC_STEP = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef logic signed [PT_W-1:0] pt_t;
	typedef pt_t [PTS_PER_CURVE-1:0] pts_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef pos_t [LANES-1:0] lanes_t;

	typedef struct packed {
		lanes_t org;
		lanes_t dst;
	} vec_pair_t;

	typedef struct packed {
		logic run;
		logic [TIME_W-1:0] t;
	} bez_ctl_t;
endpackage

@@ hdl/bei_curve_mem.sv @@
`timescale 1ns / 1ps
// Curve control-point memory: one row of four points per curve, point read-modify-write.
// Depends on bei_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bei_curve_mem #(
	parameter int NUM_CURVES = bei_pkg::NUM_CURVES_DEF,
	localparam int ROW_W = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc,
	input  logic                         func,
	input  logic [bei_pkg::CURVE_W-1:0]  curve,
	input  logic [bei_pkg::POINT_W-1:0]  point,
	input  bei_pkg::pt_t                 value,
	output logic                         step_s1,
	output bei_pkg::pts_t                pts_s1
);
	function automatic logic [ROW_W-1:0] row_of(input logic [bei_pkg::CURVE_W-1:0] c);
		logic [ROW_W-1:0] r;
		r = '0;
		for (int i = 0; i < 2 ** bei_pkg::CURVE_W; i++) begin
			if (c == i[bei_pkg::CURVE_W-1:0]) r = ROW_W'(i % NUM_CURVES);
		end
		return r;
	endfunction

	bei_pkg::pts_t mem [0:NUM_CURVES-1];

	logic [ROW_W-1:0]            row_in;
	logic                        wr_s1;
	logic [ROW_W-1:0]            row_s1;
	logic [bei_pkg::POINT_W-1:0] point_s1;
	bei_pkg::pt_t                value_s1;
	bei_pkg::pts_t               rd_s1;
	logic                        fwd_q;
	bei_pkg::pts_t               fwd_data_q;
	bei_pkg::pts_t               cur;
	bei_pkg::pts_t               wdata;

	assign row_in = row_of(curve);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			step_s1 <= 1'b0;
			fwd_q <= 1'b0;
		end else begin
			wr_s1 <= acc && (func == bei_pkg::FUNC_WRITE);
			step_s1 <= acc && (func == bei_pkg::FUNC_STEP);
			fwd_q <= wr_s1 && (row_s1 == row_in);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wdata;
		if (acc) begin
			row_s1 <= row_in;
			point_s1 <= point;
			value_s1 <= value;
			rd_s1 <= mem[row_in];
		end
		if (wr_s1) mem[row_s1] <= wdata;
	end

	// write landing on the same edge as the read: take the merged row
	always_comb begin
		cur = fwd_q ? fwd_data_q : rd_s1;
		wdata = cur;
		wdata[point_s1] = value_s1;
	end

	assign pts_s1 = cur;

	`BEI_ASSERT_NEXT(a_fwd_after_write, clk, arst_n, !wr_s1, !fwd_q)
	`BEI_ASSERT_IMPL(a_one_kind, clk, arst_n, wr_s1, !step_s1)
endmodule

@@ hdl/bei_bezier.sv @@
`timescale 1ns / 1ps
// De Casteljau evaluation of the curve y at time t, three levels of two stages.
// Depends on bei_pkg.
module bei_bezier (
	input  logic              clk,
	input  logic              arst_n,
	input  bei_pkg::bez_ctl_t ctl_s1,
	input  bei_pkg::pts_t     pts_s1,
	output bei_pkg::bez_ctl_t ctl_s7,
	output bei_pkg::pt_t      y_s7
);
	localparam int BMUL_W = bei_pkg::PT_W + bei_pkg::TIME_W + 2;

	typedef logic signed [BMUL_W-1:0] bmul_t;

	function automatic bmul_t bez_mul(input bei_pkg::pt_t a, input bei_pkg::pt_t b,
			input logic [bei_pkg::TIME_W-1:0] t);
		logic signed [bei_pkg::PT_W:0] d;
		d = {b[bei_pkg::PT_W-1], b} - {a[bei_pkg::PT_W-1], a};
		return BMUL_W'(d) * BMUL_W'($signed({1'b0, t}));
	endfunction

	// a + floor((m + half) / 4096)
	function automatic bei_pkg::pt_t bez_add(input bei_pkg::pt_t a, input bmul_t m);
		bmul_t r;
		r = (m + $signed(BMUL_W'(bei_pkg::HALF_Q12))) >>> bei_pkg::FRAC_W;
		return bei_pkg::PT_W'(BMUL_W'(a) + r);
	endfunction

	bei_pkg::bez_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	bmul_t             m01_s2, m12_s2, m23_s2, mab_s4, mbc_s4, mde_s6;
	bei_pkg::pt_t      p0_s2, p1_s2, p2_s2;
	bei_pkg::pt_t      a_s3, b_s3, c_s3, a_s4, b_s4, d_s5, e_s5, d_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_ff @(posedge clk) begin
		m01_s2 <= bez_mul(pts_s1[0], pts_s1[1], ctl_s1.t);
		m12_s2 <= bez_mul(pts_s1[1], pts_s1[2], ctl_s1.t);
		m23_s2 <= bez_mul(pts_s1[2], pts_s1[3], ctl_s1.t);
		p0_s2 <= pts_s1[0];
		p1_s2 <= pts_s1[1];
		p2_s2 <= pts_s1[2];

		a_s3 <= bez_add(p0_s2, m01_s2);
		b_s3 <= bez_add(p1_s2, m12_s2);
		c_s3 <= bez_add(p2_s2, m23_s2);

		mab_s4 <= bez_mul(a_s3, b_s3, ctl_s3.t);
		mbc_s4 <= bez_mul(b_s3, c_s3, ctl_s3.t);
		a_s4 <= a_s3;
		b_s4 <= b_s3;

		d_s5 <= bez_add(a_s4, mab_s4);
		e_s5 <= bez_add(b_s4, mbc_s4);

		mde_s6 <= bez_mul(d_s5, e_s5, ctl_s5.t);
		d_s6 <= d_s5;

		y_s7 <= bez_add(d_s6, mde_s6);
	end
endmodule

@@ hdl/bei_lerp_out.sv @@
`timescale 1ns / 1ps
// Final start-to-end interpolation by the eased value, three lanes, with saturation.
// Depends on bei_pkg.
module bei_lerp_out (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bei_pkg::bez_ctl_t               ctl_s7,
	input  bei_pkg::pt_t                    y_s7,
	input  bei_pkg::vec_pair_t              vec_s7,
	output logic                            done,
	output logic [bei_pkg::TIME_W-1:0]      new_time,
	output bei_pkg::pt_t                    eased,
	output bei_pkg::lanes_t                 out_l
);
	localparam int FMUL_W = bei_pkg::POS_W + 1 + bei_pkg::PT_W;

	typedef logic signed [FMUL_W-1:0] fmul_t;

	function automatic fmul_t fin_mul(input bei_pkg::pos_t s, input bei_pkg::pos_t e,
			input bei_pkg::pt_t y);
		logic signed [bei_pkg::POS_W:0] d;
		d = {e[bei_pkg::POS_W-1], e} - {s[bei_pkg::POS_W-1], s};
		return FMUL_W'(d) * FMUL_W'(y);
	endfunction

	function automatic bei_pkg::pos_t fin_add(input bei_pkg::pos_t s, input fmul_t m);
		fmul_t                              r;
		fmul_t                              sum;
		logic [FMUL_W-bei_pkg::POS_W:0]     hi;
		bei_pkg::pos_t                      res;
		r = (m + $signed(FMUL_W'(bei_pkg::HALF_Q12))) >>> bei_pkg::FRAC_W;
		sum = FMUL_W'(s) + r;
		hi = sum[FMUL_W-1:bei_pkg::POS_W-1];
		if (hi == '0 || hi == '1) res = sum[bei_pkg::POS_W-1:0];
		else if (sum[FMUL_W-1]) res = {1'b1, {(bei_pkg::POS_W-1){1'b0}}};
		else res = {1'b0, {(bei_pkg::POS_W-1){1'b1}}};
		return res;
	endfunction

	bei_pkg::bez_ctl_t ctl_s8;
	bei_pkg::pt_t      y_s8;
	bei_pkg::lanes_t   org_s8;
	fmul_t             m_s8 [bei_pkg::LANES];
	logic              done_q;
	logic [bei_pkg::TIME_W-1:0] new_time_q;
	bei_pkg::pt_t      eased_q;
	bei_pkg::lanes_t   out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s8 <= ctl_s7;
			done_q <= ctl_s8.run;
		end
	end

	always_ff @(posedge clk) begin
		y_s8 <= y_s7;
		org_s8 <= vec_s7.org;
		for (int i = 0; i < bei_pkg::LANES; i++) begin
			m_s8[i] <= fin_mul(vec_s7.org[i], vec_s7.dst[i], y_s7);
			out_q[i] <= fin_add(org_s8[i], m_s8[i]);
		end
		new_time_q <= ctl_s8.t;
		eased_q <= y_s8;
	end

	assign done = done_q;
	assign new_time = new_time_q;
	assign eased = eased_q;
	assign out_l = out_q;
endmodule

@@ hdl/bezier_easing_interpolator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the cubic Bezier easing step block.
// Depends on bei_pkg, bei_curve_mem, bei_bezier, bei_lerp_out and assert_macros.svh.
//
// One word is taken in every clock cycle (busy stays low). A step word passes nine
// register stages: done and the result are registered together in the last of them,
// and the result is valid while done is high; the receiver must take it then.
// A write word gives no result. The four control points
// of a curve sit in one memory row that a step reads in a single access; a write
// reads that row, replaces one point and writes it back the next cycle, with the
// merged row forwarded so a word right behind it already sees the new value.
`include "assert_macros.svh"
module bezier_easing_interpolator_unit #(
	parameter int NUM_CURVES = bei_pkg::NUM_CURVES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [bei_pkg::CURVE_W-1:0]    curve,
	input  logic [bei_pkg::POINT_W-1:0]    point,
	input  logic signed [bei_pkg::PT_W-1:0]  point_value,
	input  logic [bei_pkg::TIME_W-1:0]     current_time,
	input  logic [bei_pkg::TIME_W-1:0]     step,
	input  logic signed [bei_pkg::POS_W-1:0] start_x,
	input  logic signed [bei_pkg::POS_W-1:0] start_y,
	input  logic signed [bei_pkg::POS_W-1:0] start_z,
	input  logic signed [bei_pkg::POS_W-1:0] end_x,
	input  logic signed [bei_pkg::POS_W-1:0] end_y,
	input  logic signed [bei_pkg::POS_W-1:0] end_z,
	output logic                           done,
	output logic [bei_pkg::TIME_W-1:0]     new_time,
	output logic signed [bei_pkg::PT_W-1:0]  eased,
	output logic signed [bei_pkg::POS_W-1:0] out_x,
	output logic signed [bei_pkg::POS_W-1:0] out_y,
	output logic signed [bei_pkg::POS_W-1:0] out_z
);
	logic                       acc;
	logic [bei_pkg::TIME_W:0]   sum;
	logic [bei_pkg::TIME_W-1:0] t_in;
	logic [bei_pkg::TIME_W-1:0] t_s1;
	logic                       step_s1;
	bei_pkg::pts_t              pts_s1;
	bei_pkg::bez_ctl_t          ctl_s1;
	bei_pkg::bez_ctl_t          ctl_s7;
	bei_pkg::pt_t               y_s7;
	bei_pkg::vec_pair_t         vec_s1, vec_s2, vec_s3, vec_s4, vec_s5, vec_s6, vec_s7;
	bei_pkg::lanes_t            out_l;

	assign busy = 1'b0;
	assign acc = start && !busy;

	assign sum = {1'b0, current_time} + {1'b0, step};
	assign t_in = (sum > {1'b0, bei_pkg::ONE_Q12}) ? bei_pkg::ONE_Q12
		: sum[bei_pkg::TIME_W-1:0];

	always_ff @(posedge clk) begin
		if (acc) begin
			t_s1 <= t_in;
			vec_s1.org[0] <= start_x;
			vec_s1.org[1] <= start_y;
			vec_s1.org[2] <= start_z;
			vec_s1.dst[0] <= end_x;
			vec_s1.dst[1] <= end_y;
			vec_s1.dst[2] <= end_z;
		end
		vec_s2 <= vec_s1;
		vec_s3 <= vec_s2;
		vec_s4 <= vec_s3;
		vec_s5 <= vec_s4;
		vec_s6 <= vec_s5;
		vec_s7 <= vec_s6;
	end

	assign ctl_s1 = '{run: step_s1, t: t_s1};

	bei_curve_mem #(
		.NUM_CURVES (NUM_CURVES)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.func    (func),
		.curve   (curve),
		.point   (point),
		.value   (point_value),
		.step_s1 (step_s1),
		.pts_s1  (pts_s1)
	);

	bei_bezier u_bez (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.pts_s1 (pts_s1),
		.ctl_s7 (ctl_s7),
		.y_s7   (y_s7)
	);

	bei_lerp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s7   (ctl_s7),
		.y_s7     (y_s7),
		.vec_s7   (vec_s7),
		.done     (done),
		.new_time (new_time),
		.eased    (eased),
		.out_l    (out_l)
	);

	assign out_x = out_l[0];
	assign out_y = out_l[1];
	assign out_z = out_l[2];

	`BEI_ASSERT_IMPL(a_done_from_step, clk, arst_n, done, $past(acc && (func == bei_pkg::FUNC_STEP), 9))
	`BEI_ASSERT_IMPL(a_write_no_result, clk, arst_n, acc && (func == bei_pkg::FUNC_WRITE), ##9 !done)
endmodule
